>>> hw/rtl/pdfd_pkg.sv
// Shared types and constants for the pulse-distance frame decoder.
package pdfd_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned SHIFT_W  = 6;
    localparam int unsigned APB_DW   = 32;
    localparam int unsigned APB_AW   = 4;
    localparam int unsigned REG_IDX_W = 2;

    localparam logic [TIME_W-1:0]  THRESHOLD_RESET = TIME_W'(1000);
    localparam logic [TIME_W-1:0]  GAP_RESET       = TIME_W'(5000);
    localparam logic [COUNT_W-1:0] LENGTH_RESET    = COUNT_W'(40);

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_GAP = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_LENGTH    = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0]  bit_limit_us;
        logic [TIME_W-1:0]  gap_limit_us;
        logic [COUNT_W-1:0] frame_length;
    } pdfd_cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0]  prev_time;
        logic [COUNT_W-1:0] bits_received;
        logic [WORD_W-1:0]  assembly_word;
    } pdfd_state_t;

endpackage

>>> hw/rtl/pdfd_step.sv
// Single-edge decode step: gap, frame start, bit decision and completion.
module pdfd_step (
    input  logic [pdfd_pkg::TIME_W-1:0] edge_time_us,
    input  pdfd_pkg::pdfd_cfg_t         cfg,
    input  pdfd_pkg::pdfd_state_t       state_cur,
    output pdfd_pkg::pdfd_state_t       state_next,
    output logic                        emit,
    output logic [pdfd_pkg::WORD_W-1:0] emit_word
);

    logic [pdfd_pkg::TIME_W-1:0]  gap;
    logic                         frame_start;
    logic                         frame_full;
    logic                         bit_one;
    logic [pdfd_pkg::COUNT_W-1:0] count_inc;
    logic [pdfd_pkg::WORD_W-1:0]  bit_mask;
    logic [pdfd_pkg::WORD_W-1:0]  word_upd;

    // Gap wraps modulo 2^32 by construction.
    assign gap         = edge_time_us - state_cur.prev_time;
    assign frame_start = gap > cfg.gap_limit_us;
    assign frame_full  = state_cur.bits_received >= cfg.frame_length;
    // Positions 64 and up are counted but not stored.
    assign bit_one     = (gap < cfg.bit_limit_us)
                         && !state_cur.bits_received[pdfd_pkg::COUNT_W-1];
    assign count_inc   = state_cur.bits_received + pdfd_pkg::COUNT_W'(1);
    assign bit_mask    = {{(pdfd_pkg::WORD_W-1){1'b0}}, bit_one}
                         << state_cur.bits_received[pdfd_pkg::SHIFT_W-1:0];
    assign word_upd    = state_cur.assembly_word | bit_mask;

    always_comb begin
        state_next           = state_cur;
        state_next.prev_time = edge_time_us;
        emit                 = 1'b0;
        if (frame_start) begin
            state_next.bits_received = '0;
            state_next.assembly_word = '0;
        end else if (!frame_full) begin
            state_next.bits_received = count_inc;
            state_next.assembly_word = word_upd;
            emit                     = (count_inc == cfg.frame_length);
        end
    end

    assign emit_word = word_upd;

endmodule

>>> hw/rtl/pulse_distance_frame_decoder_unit.sv
// Top level of the pulse-distance frame decoder with APB register port.
//
// Usage:
//   s_ channel carries one falling-edge beat (s_edge_time_us, free-running
//   microsecond timestamp). m_ channel carries one completed frame word per
//   finished frame (m_frame_word, first received bit in bit 0).
//   Most edges produce no beat on m_; only the edge that fills the frame does.
//   APB port: 0x0 bit threshold, 0x4 frame gap, 0x8 frame length.
//   Write registers only while the decoder is idle.
// Timing:
//   An edge beat lands in an input register, is decoded from there once the
//   output slot is free or draining, and its frame word (if any) is then
//   registered in the output register that drives m_.
//   Throughput is one edge per cycle while m_ keeps up.
// Stall / reset:
//   A stalled m_ beat holds; the input register still takes one more edge.
//   Reset restores default registers and clears timestamp, count and word
//   (the first edge measures its gap from time zero).
module pulse_distance_frame_decoder_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    // edge input
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [pdfd_pkg::TIME_W-1:0]    s_edge_time_us,
    // frame output
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [pdfd_pkg::WORD_W-1:0]    m_frame_word,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pdfd_pkg::APB_AW-1:0]    paddr,
    input  logic [pdfd_pkg::APB_DW-1:0]    pwdata,
    output logic [pdfd_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);

    pdfd_pkg::pdfd_cfg_t   cfg_reg;
    pdfd_pkg::pdfd_state_t state_reg;
    pdfd_pkg::pdfd_state_t state_next;

    logic                          in_valid_reg;
    logic [pdfd_pkg::TIME_W-1:0]   in_time_reg;
    logic                          out_valid_reg;
    logic [pdfd_pkg::WORD_W-1:0]   out_word_reg;

    logic                          proc_go;
    logic                          step_emit;
    logic [pdfd_pkg::WORD_W-1:0]   step_word;
    logic                          cfg_wr;
    logic [pdfd_pkg::REG_IDX_W-1:0] reg_idx;

    // ---------------- register port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[pdfd_pkg::APB_AW-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bit_limit_us <= pdfd_pkg::THRESHOLD_RESET;
            cfg_reg.gap_limit_us <= pdfd_pkg::GAP_RESET;
            cfg_reg.frame_length <= pdfd_pkg::LENGTH_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                pdfd_pkg::REG_THRESHOLD: cfg_reg.bit_limit_us <= pwdata;
                pdfd_pkg::REG_FRAME_GAP: cfg_reg.gap_limit_us <= pwdata;
                pdfd_pkg::REG_LENGTH:
                    cfg_reg.frame_length <= pwdata[pdfd_pkg::COUNT_W-1:0];
                default: ; // unmapped: ignored
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            pdfd_pkg::REG_THRESHOLD: prdata = cfg_reg.bit_limit_us;
            pdfd_pkg::REG_FRAME_GAP: prdata = cfg_reg.gap_limit_us;
            pdfd_pkg::REG_LENGTH:
                prdata = {{(pdfd_pkg::APB_DW-pdfd_pkg::COUNT_W){1'b0}},
                          cfg_reg.frame_length};
            default: prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    // Decode runs when an edge is held and the output slot is free or draining.
    assign proc_go = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proc_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_time_reg <= s_edge_time_us;
        end
    end

    // ---------------- decode step ----------------
    pdfd_step u_step (
        .edge_time_us (in_time_reg),
        .cfg          (cfg_reg),
        .state_cur    (state_reg),
        .state_next   (state_next),
        .emit         (step_emit),
        .emit_word    (step_word)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (proc_go) begin
            state_reg <= state_next;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_go) begin
            out_valid_reg <= step_emit;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_go && step_emit) begin
            out_word_reg <= step_word;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_frame_word = out_word_reg;

endmodule

>>> hw/rtl/pdfd_checker.sv
// Port-level checker for the frame decoder, bound to the top level.
module pdfd_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [pdfd_pkg::WORD_W-1:0] m_frame_word,
    input logic                        pready
);

    // Input side only backs up behind a waiting frame beat.
    a_ready_only_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("s_ready low without pending m_ beat");

    // Reset leaves no frame pending and the input open.
    a_reset_clean: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("state not clean after reset");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_frame_word)))
        else $error("stalled m_ beat changed");

    a_pready_high: assert property (@(posedge aclk) pready)
        else $error("pready dropped");

endmodule

bind pulse_distance_frame_decoder_unit pdfd_checker u_pdfd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_frame_word (m_frame_word),
    .pready       (pready)
);
